FILE: hdl/b64sd_pkg.sv
// Package: constants, types and the character map of the base64 stream decoder.
package b64sd_pkg;

    localparam int          MAX_OUTPUT_DEF = 1024;
    localparam int          CNT_W          = 11;
    localparam logic [10:0] CAP_RESET      = 11'd64;
    localparam logic [7:0]  PAD_CHAR       = 8'h3D;
    localparam logic [7:0]  END_CHAR       = 8'h00;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_OVER_CAP = 2'd2
    } status_t;

    // One queued result group: up to three bytes, or a single status result.
    typedef struct packed {
        logic [23:0]      bits;
        logic [1:0]       nout;
        logic [CNT_W-1:0] base;
        logic             status;
        status_t          code;
    } grp_t;

    // {valid, sextet}
    function automatic logic [6:0] sextet_of(input logic [7:0] ch);
        logic [6:0] r;
        r = 7'd0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            r = {1'b1, 6'(ch - 8'h41)};
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            r = {1'b1, 6'(ch - 8'h61 + 8'd26)};
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            r = {1'b1, 6'(ch - 8'h30 + 8'd52)};
        end else if (ch == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (ch == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

FILE: hdl/base64_stream_decoder.sv
// Base64 stream decoder: one character per transaction in, decoded bytes and status out.
//
// Usage:
//   Input channel (char_valid, char_stall, char_code) takes one character per
//   transaction. Every fourth character closes a group that yields one to three data
//   results, or none once an error is flagged; a zero character yields one status result
//   (is_status = 1) carrying the error code and byte count, and starts a new string.
//   Result channel (res_valid, res_stall) delivers one result per transaction;
//   last marks the final result of an input character.
//   Configuration channel (cfg_valid, cfg_ready, cfg_data) writes the output
//   capacity; cfg_ready is always high. Write only while the block is idle.
// Timing:
//   A character is decoded in the cycle it is accepted, and a closing group is
//   registered into the result queue. A character is accepted every cycle while
//   char_stall is low; a group drains from a two-group result queue at one result
//   per cycle while res_stall is low; char_stall rises only when both slots are full.
// Reset: clears the string state and queue, capacity returns to 64.
// Stall: when res_stall holds, the current result is held unchanged and
//   the queue fills; input then stalls until a slot frees.
module base64_stream_decoder #(
    parameter int MAX_OUTPUT = b64sd_pkg::MAX_OUTPUT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       char_valid,
    output logic                       char_stall,
    input  logic [7:0]                 char_code,
    output logic                       res_valid,
    input  logic                       res_stall,
    output logic [7:0]                 out_byte,
    output logic                       is_status,
    output logic [1:0]                 status_code,
    output logic [b64sd_pkg::CNT_W-1:0] byte_count,
    output logic                       last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [b64sd_pkg::CNT_W-1:0] cfg_data
);
    import b64sd_pkg::*;

    localparam int               CapLim  = (MAX_OUTPUT > 2047) ? 2047 : MAX_OUTPUT;
    localparam logic [CNT_W-1:0] CAP_LIM = CNT_W'(CapLim);

    logic [CNT_W-1:0] cap_reg;
    logic [1:0]       pos_reg, pos_next;
    logic [17:0]      acc_reg, acc_next;
    logic             pad_reg, pad_next;
    logic             bad_reg, bad_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    status_t          err_reg, err_next;

    grp_t             head_reg, tail_reg;
    logic             head_vld_reg, tail_vld_reg;
    logic [1:0]       idx_reg;

    logic             accept, push, pop, res_take;
    grp_t             new_grp;
    logic [6:0]       sx;
    logic [5:0]       s;
    logic             pad_here;
    logic [1:0]       nout;
    logic             bad_fin;
    logic [CNT_W:0]   sum;
    logic [CNT_W-1:0] cap_eff;
    logic [17:0]      acc_base;
    logic             pad_base, bad_base;

    assign cfg_ready  = 1'b1;
    assign char_stall = tail_vld_reg;
    assign accept     = char_valid && !char_stall;
    assign cap_eff    = (cap_reg > CAP_LIM) ? CAP_LIM : cap_reg;
    assign sx         = sextet_of(char_code);

    always_comb
    begin
        pos_next = pos_reg;
        acc_next = acc_reg;
        pad_next = pad_reg;
        bad_next = bad_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        push     = 1'b0;
        new_grp  = '0;
        acc_base = (pos_reg == 2'd0) ? 18'd0 : acc_reg;
        pad_base = (pos_reg == 2'd0) ? 1'b0 : pad_reg;
        bad_base = (pos_reg == 2'd0) ? 1'b0 : bad_reg;
        pad_here = (char_code == PAD_CHAR);
        s        = sx[6] ? sx[5:0] : 6'd0;
        nout     = pad_reg ? 2'd1 : (pad_here ? 2'd2 : 2'd3);
        bad_fin  = bad_reg || (!pad_here && !sx[6]);
        sum      = {1'b0, cnt_reg} + (CNT_W+1)'(nout);
        if (accept) begin
            if (char_code == END_CHAR) begin
                push           = 1'b1;
                new_grp.status = 1'b1;
                new_grp.code   = err_reg;
                new_grp.nout   = 2'd1;
                new_grp.base   = cnt_reg;
                pos_next       = 2'd0;
                acc_next       = 18'd0;
                pad_next       = 1'b0;
                bad_next       = 1'b0;
                cnt_next       = '0;
                err_next       = ST_OK;
            end else if (err_reg == ST_OK) begin
                if (pos_reg != 2'd3) begin
                    pos_next = pos_reg + 2'd1;
                    if (pos_reg == 2'd2 && pad_here) begin
                        acc_next = {acc_base[11:0], 6'd0};
                        pad_next = 1'b1;
                        bad_next = bad_base;
                    end else begin
                        acc_next = {acc_base[11:0], s};
                        pad_next = pad_base;
                        bad_next = bad_base || !sx[6];
                    end
                end else begin
                    pos_next = 2'd0;
                    if (bad_fin) begin
                        err_next = ST_BAD_CHAR;
                    end else if (sum > {1'b0, cap_eff}) begin
                        err_next = ST_OVER_CAP;
                    end else begin
                        push         = 1'b1;
                        new_grp.bits = {acc_reg, pad_here ? 6'd0 : s};
                        new_grp.nout = nout;
                        new_grp.base = cnt_reg;
                        new_grp.code = ST_OK;
                        cnt_next     = sum[CNT_W-1:0];
                    end
                end
            end
        end
    end

    assign res_valid = head_vld_reg;
    assign res_take  = res_valid && !res_stall;
    assign pop       = res_take && last;

    always_comb
    begin
        is_status   = head_reg.status;
        status_code = head_reg.code;
        last        = (idx_reg == head_reg.nout - 2'd1);
        byte_count  = head_reg.status ? head_reg.base
                                      : head_reg.base + CNT_W'(idx_reg) + CNT_W'(1);
        case (idx_reg)
            2'd0:    out_byte = head_reg.bits[23:16];
            2'd1:    out_byte = head_reg.bits[15:8];
            2'd2:    out_byte = head_reg.bits[7:0];
            default: out_byte = 8'd0;
        endcase
        if (head_reg.status) begin
            out_byte = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg      <= CAP_RESET;
            pos_reg      <= 2'd0;
            acc_reg      <= 18'd0;
            pad_reg      <= 1'b0;
            bad_reg      <= 1'b0;
            cnt_reg      <= '0;
            err_reg      <= ST_OK;
            head_vld_reg <= 1'b0;
            tail_vld_reg <= 1'b0;
            idx_reg      <= 2'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            pos_reg <= pos_next;
            acc_reg <= acc_next;
            pad_reg <= pad_next;
            bad_reg <= bad_next;
            cnt_reg <= cnt_next;
            err_reg <= err_next;
            if (res_take) begin
                idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
            end
            if (pop && push) begin
                tail_vld_reg <= tail_vld_reg;
            end else if (pop) begin
                head_vld_reg <= tail_vld_reg;
                tail_vld_reg <= 1'b0;
            end else if (push) begin
                if (!head_vld_reg) begin
                    head_vld_reg <= 1'b1;
                end else begin
                    tail_vld_reg <= 1'b1;
                end
            end
        end
    end

    // Queue payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (pop && push) begin
            if (tail_vld_reg) begin
                head_reg <= tail_reg;
                tail_reg <= new_grp;
            end else begin
                head_reg <= new_grp;
            end
        end else if (pop) begin
            head_reg <= tail_reg;
        end else if (push) begin
            if (!head_vld_reg) begin
                head_reg <= new_grp;
            end else begin
                tail_reg <= new_grp;
            end
        end
    end

`ifndef SYNTHESIS
    a_stall_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> res_valid)
        else $error("input stalled with empty result queue");

    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (idx_reg < head_reg.nout))
        else $error("result index beyond group size");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !is_status) |-> (byte_count != '0 && status_code == ST_OK))
        else $error("data result with zero count or error code");

    a_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (idx_reg == $past(idx_reg)))
        else $error("result index moved while stalled");
`endif

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for base64_stream_decoder: directed table, then random strings.
`timescale 1ns / 100ps

module tb_top;

    import b64sd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 150;

    typedef struct {
        logic [7:0]       byte_val;
        logic             is_st;
        status_t          code;
        logic [CNT_W-1:0] count;
        logic             last_flag;
    } decoded_result_t;

    typedef struct {
        logic             set_cap;
        logic [CNT_W-1:0] cap;
        logic [7:0]       ch;
        logic             typed;
        status_t          code;
        logic [CNT_W-1:0] count;
    } stim_row_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             char_valid  = 1'b0;
    logic             char_stall;
    logic [7:0]       char_code   = 8'h00;
    logic             res_valid;
    logic             res_stall   = 1'b0;
    logic [7:0]       out_byte;
    logic             is_status;
    logic [1:0]       status_code;
    logic [CNT_W-1:0] byte_count;
    logic             last;
    logic             cfg_valid   = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data    = '0;

    // predictor state
    logic [1:0]       grp_pos  = 2'd0;
    logic [17:0]      sext_acc = 18'd0;
    logic             pad3     = 1'b0;
    logic             grp_bad  = 1'b0;
    logic [CNT_W-1:0] dec_cnt  = '0;
    status_t          err      = ST_OK;
    logic [CNT_W-1:0] capacity = CAP_RESET;

    decoded_result_t  expected_results[$];
    int               error_count = 0;
    int               cycle_count = 0;
    bit               calm        = 1'b0;
    bit               long_hold   = 1'b0;

    stim_row_t stimulus_rows [27] = '{
        '{1'b0, 11'd0, END_CHAR, 1'b1, ST_OK,       11'd0},
        '{1'b0, 11'd0, "/",      1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, "+",      1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, "9",      1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, "z",      1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, "A",      1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, "Z",      1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, PAD_CHAR, 1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, "a",      1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, "Q",      1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, "U",      1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, "I",      1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, PAD_CHAR, 1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, 8'hFF,    1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, 8'h80,    1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, END_CHAR, 1'b1, ST_OK,       11'd6},
        '{1'b1, 11'd0, 8'h00,    1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, PAD_CHAR, 1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, "A",      1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, "A",      1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, "A",      1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, END_CHAR, 1'b1, ST_BAD_CHAR, 11'd0},
        '{1'b0, 11'd0, "T",      1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, "W",      1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, "F",      1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, "u",      1'b0, ST_OK,       11'd0},
        '{1'b0, 11'd0, END_CHAR, 1'b1, ST_OVER_CAP, 11'd0}
    };

    base64_stream_decoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_code   (char_code),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .out_byte    (out_byte),
        .is_status   (is_status),
        .status_code (status_code),
        .byte_count  (byte_count),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int sextet_value(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z")
        begin
            return int'(ch - "A");
        end
        if (ch >= "a" && ch <= "z")
        begin
            return int'(ch - "a") + 26;
        end
        if (ch >= "0" && ch <= "9")
        begin
            return int'(ch - "0") + 52;
        end
        if (ch == "+")
        begin
            return 62;
        end
        if (ch == "/")
        begin
            return 63;
        end
        return -1;
    endfunction

    function automatic logic [7:0] alpha_char(input int v);
        if (v < 26)
        begin
            return 8'("A" + v);
        end
        if (v < 52)
        begin
            return 8'("a" + v - 26);
        end
        if (v < 62)
        begin
            return 8'("0" + v - 52);
        end
        return (v == 62) ? 8'("+") : 8'("/");
    endfunction

    function automatic logic [7:0] noise_char();
        if ($urandom_range(0, 3) == 0)
        begin
            return PAD_CHAR;
        end
        return 8'($urandom_range(1, 255));
    endfunction

    // expected results of one accepted character
    task automatic decode_expected(input logic [7:0] ch);
        int              s;
        int              nout;
        int              cap;
        logic [23:0]     word;
        decoded_result_t r;
        if (ch == END_CHAR)
        begin
            r = '{8'h00, 1'b1, err, dec_cnt, 1'b1};
            expected_results.push_back(r);
            grp_pos  = 2'd0;
            sext_acc = 18'd0;
            pad3     = 1'b0;
            grp_bad  = 1'b0;
            dec_cnt  = '0;
            err      = ST_OK;
            return;
        end
        if (err != ST_OK)
        begin
            return;
        end
        if (grp_pos == 2'd0)
        begin
            sext_acc = 18'd0;
            pad3     = 1'b0;
            grp_bad  = 1'b0;
        end
        if (grp_pos != 2'd3)
        begin
            if (grp_pos == 2'd2 && ch == PAD_CHAR)
            begin
                s    = 0;
                pad3 = 1'b1;
            end
            else
            begin
                s = sextet_value(ch);
                if (s < 0)
                begin
                    grp_bad = 1'b1;
                    s       = 0;
                end
            end
            sext_acc = {sext_acc[11:0], 6'(s)};
            grp_pos++;
            return;
        end
        grp_pos = 2'd0;
        nout    = 3;
        s       = 0;
        if (ch == PAD_CHAR)
        begin
            nout = 2;
        end
        else
        begin
            s = sextet_value(ch);
            if (s < 0)
            begin
                grp_bad = 1'b1;
                s       = 0;
            end
        end
        if (pad3)
        begin
            nout = 1;
        end
        if (grp_bad)
        begin
            err = ST_BAD_CHAR;
            return;
        end
        cap = (capacity > MAX_OUTPUT_DEF) ? MAX_OUTPUT_DEF : int'(capacity);
        if (int'(dec_cnt) + nout > cap)
        begin
            err = ST_OVER_CAP;
            return;
        end
        word = {sext_acc, 6'(s)};
        for (int k = 0; k < nout; k++)
        begin
            dec_cnt++;
            r = '{word[23 - 8 * k -: 8], 1'b0, ST_OK, dec_cnt, (k == nout - 1)};
            expected_results.push_back(r);
        end
    endtask

    task automatic send_char(input logic [7:0] ch, input bit may_idle);
        if (may_idle && $urandom_range(0, 5) == 0)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_code  <= ch;
        @(posedge clk);
        while (char_stall) @(posedge clk);
        decode_expected(ch);
    endtask

    task automatic wait_for_quiet();
        char_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        capacity  = v;
    endtask

    // groups of valid characters with random padding, noise and a ragged tail
    task automatic send_random_string(input bit may_idle, input int min_groups,
                                      input int max_groups, output int n_sent);
        logic [7:0] chars[$];
        logic [7:0] grp[4];
        int         ngroups;
        ngroups = $urandom_range(min_groups, max_groups);
        for (int g = 0; g < ngroups; g++)
        begin
            for (int p = 0; p < 4; p++)
            begin
                grp[p] = alpha_char($urandom_range(0, 63));
            end
            case ($urandom_range(0, 11))
                0, 1:
                begin
                    grp[2] = PAD_CHAR;
                    grp[3] = PAD_CHAR;
                end
                2, 3:    grp[3] = PAD_CHAR;
                4:       grp[2] = PAD_CHAR;
                5:       grp[$urandom_range(0, 3)] = noise_char();
                default: ;
            endcase
            foreach (grp[p])
            begin
                chars.push_back(grp[p]);
            end
        end
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                chars.push_back($urandom_range(0, 1) ? alpha_char($urandom_range(0, 63))
                                                     : noise_char());
            end
        end
        chars.push_back(END_CHAR);
        foreach (chars[i])
        begin
            send_char(chars[i], may_idle);
        end
        n_sent = chars.size();
    endtask

    // result side back-pressure
    initial
    begin
        bit v;
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                v         = 1'b1;
                n         = 60;
                long_hold = 1'b0;
            end
            else if (calm)
            begin
                v = 1'b0;
                n = 1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                v = 1'b1;
                n = $urandom_range(1, 12);
            end
            else
            begin
                v = 1'b0;
                n = $urandom_range(1, 12);
            end
            res_stall <= v;
            repeat (n) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        decoded_result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected transaction: out_byte %0d is_status %0b", out_byte, is_status);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_byte !== want.byte_val)
                begin
                    $error("out_byte: expected %0d, got %0d", want.byte_val, out_byte);
                    error_count++;
                end
                if (is_status !== want.is_st)
                begin
                    $error("is_status: expected %0d, got %0d", want.is_st, is_status);
                    error_count++;
                end
                if (status_code !== want.code)
                begin
                    $error("status_code: expected %0d, got %0d", want.code, status_code);
                    error_count++;
                end
                if (byte_count !== want.count)
                begin
                    $error("byte_count: expected %0d, got %0d", want.count, byte_count);
                    error_count++;
                end
                if (last !== want.last_flag)
                begin
                    $error("last: expected %0d, got %0d", want.last_flag, last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [CNT_W-1:0] cap_steps [6];
        int               random_items;
        int               phase_items;
        int               phase;
        int               n_sent;
        bit               may_idle;
        cap_steps    = '{11'd0, 11'd2047, 11'd1, 11'd5, 11'd1024, 11'd64};
        random_items = 0;
        phase        = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stimulus_rows[i])
        begin
            if (stimulus_rows[i].set_cap)
            begin
                wait_for_quiet();
                write_capacity(stimulus_rows[i].cap);
            end
            else
            begin
                send_char(stimulus_rows[i].ch, 1'b1);
                if (stimulus_rows[i].typed)
                begin
                    expected_results[expected_results.size() - 1] =
                        '{8'h00, 1'b1, stimulus_rows[i].code, stimulus_rows[i].count, 1'b1};
                end
            end
        end

        while (random_items < RANDOM_ITEMS)
        begin
            wait_for_quiet();
            if (phase < 6)
            begin
                write_capacity(cap_steps[phase]);
            end
            else
            begin
                write_capacity(CNT_W'($urandom_range(0, 40)));
            end
            calm        = (random_items >= RANDOM_ITEMS - 40);
            may_idle    = !calm && ($urandom_range(0, 3) != 0);
            phase_items = 0;
            if (phase == 1)
            begin
                // hold the result side while characters keep coming
                long_hold = 1'b1;
                wait (res_stall);
                @(posedge clk);
                send_random_string(1'b0, 8, 10, n_sent);
                phase_items += n_sent;
            end
            while (phase_items < 30)
            begin
                send_random_string(may_idle, 0, 5, n_sent);
                phase_items += n_sent;
            end
            random_items += phase_items;
            phase++;
        end

        char_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/b64sd_pkg.sv
hdl/base64_stream_decoder.sv
test/tb_top.sv
